// ----- rtl/kds_pkg.sv -----
// ----------------------------------------------------------------------------
// kds_pkg: shared types and codes for the keyed deque store
// Operation and status codes, field widths and the control bundle that the
// top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package kds_pkg;

   localparam int MODE_W = 2;
   localparam int KEY_W = 32;
   localparam int DATA_W = 64;
   localparam int STATUS_W = 2;
   localparam int DEFAULT_CAPACITY = 16;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POP = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd3;

   // broadcast to every cell
   typedef struct packed {
      logic              apply;
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
      logic              full;
      logic              empty;
   } ctl_type;

endpackage

`default_nettype wire

// ----- rtl/kds_cell.sv -----
// ----------------------------------------------------------------------------
// kds_cell: one slot of the keyed deque store
// Holds a key and a payload, compares its key against the broadcast key and
// loads from the request, its left neighbor or its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module kds_cell
   import kds_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int POSITION = 0,
   localparam int FILL_W = $clog2(CAPACITY + 1)
) (
   input  wire logic              clock,
   input  wire ctl_type           ctl,
   input  wire logic [FILL_W-1:0] fill,
   input  wire logic [KEY_W-1:0]  left_key,
   input  wire logic [DATA_W-1:0] left_data,
   input  wire logic [KEY_W-1:0]  right_key,
   input  wire logic [DATA_W-1:0] right_data,
   input  wire logic              seen_in,
   output logic [KEY_W-1:0]       key,
   output logic [DATA_W-1:0]      data,
   output logic                   seen_out
);

   localparam logic [FILL_W-1:0] POS_CODE = FILL_W'(POSITION);

   logic [KEY_W-1:0]  key_ff, key_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              occupied;
   logic              hit;
   logic              load_req;
   logic              load_left;
   logic              load_right;

   always_comb begin
      occupied = POS_CODE < fill;
      hit = occupied && (key_ff == ctl.key);
      // match seen at this slot or anywhere nearer the front
      seen_out = seen_in | hit;

      load_req = 1'b0;
      load_left = 1'b0;
      load_right = 1'b0;
      case (ctl.mode)
         MODE_APPEND: begin
            load_req = !ctl.full && (fill == POS_CODE);
         end
         MODE_PUSH: begin
            load_req = !ctl.full && (POS_CODE == '0);
            load_left = !ctl.full && (POS_CODE != '0);
         end
         MODE_POP: begin
            load_right = !ctl.empty;
         end
         MODE_DELETE: begin
            // slots from the first match on close the gap
            load_right = seen_out;
         end
         default: begin
            load_req = 1'b0;
         end
      endcase

      key_in = key_ff;
      data_in = data_ff;
      if (ctl.apply) begin
         if (load_req) begin
            key_in = ctl.key;
            data_in = ctl.data;
         end else if (load_left) begin
            key_in = left_key;
            data_in = left_data;
         end else if (load_right) begin
            key_in = right_key;
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      data_ff <= data_in;
   end

   assign key = key_ff;
   assign data = data_ff;

endmodule

`default_nettype wire

// ----- rtl/keyed_deque_store_top.sv -----
// ----------------------------------------------------------------------------
// keyed_deque_store_top: ordered record store with deque and keyed delete
// A row of storage cells, slot 0 at the front. Append, push, pop and delete
// by key each take one transaction and give one response transaction.
// ----------------------------------------------------------------------------
//
//  channel  direction  ports                                    transaction
//  req      in         req_mode, req_rec_id, req_rec_data       one operation
//  rsp      out        rsp_out_id, rsp_out_data, rsp_status     one result
//
//  every cell compares and shifts in the accept cycle
//  and the result is registered at the accepting edge
//  a request is taken in the same cycle the pending response leaves, so back
//  to back operations run at one per cycle while rsp_ready stays high
//  reset clears the fill count and response valid; slots are written before read
//  req_ready is low in reset and while a response waits with rsp_ready low
//
`default_nettype none

module keyed_deque_store_top
   import kds_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [KEY_W-1:0]    req_rec_id,
   input  wire logic [DATA_W-1:0]   req_rec_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [KEY_W-1:0]         rsp_out_id,
   output logic [DATA_W-1:0]        rsp_out_data,
   output logic [STATUS_W-1:0]      rsp_status
);

   localparam int FILL_W = $clog2(CAPACITY + 1);
   localparam logic [FILL_W-1:0] FULL_CODE = FILL_W'(CAPACITY);

   // fill count: number of records held, front is slot 0
   logic [FILL_W-1:0]   fill_ff, fill_in;
   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                accept;
   logic                found;
   ctl_type             ctl;

   logic [KEY_W-1:0]    cell_key [CAPACITY];
   logic [DATA_W-1:0]   cell_data [CAPACITY];
   logic [CAPACITY:0]   seen;

   // no transaction is taken while reset is high
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;

   // broadcast bundle for the cells
   always_comb begin
      ctl.apply = accept;
      ctl.mode = req_mode;
      ctl.key = req_rec_id;
      ctl.data = req_rec_data;
      ctl.full = fill_ff == FULL_CODE;
      ctl.empty = fill_ff == '0;
   end

   // match chain enters empty at the front
   assign seen[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_W-1:0]  left_key, right_key;
      logic [DATA_W-1:0] left_data, right_data;

      if (i == 0) begin : g_front
         // a push loads slot 0 from the request directly
         assign left_key = req_rec_id;
         assign left_data = req_rec_data;
      end else begin : g_inner_left
         assign left_key = cell_key[i-1];
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_back
         // last slot drops out of the count when the row shifts forward
         assign right_key = cell_key[i];
         assign right_data = cell_data[i];
      end else begin : g_inner_right
         assign right_key = cell_key[i+1];
         assign right_data = cell_data[i+1];
      end

      kds_cell #(
         .CAPACITY (CAPACITY),
         .POSITION (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .fill       (fill_ff),
         .left_key   (left_key),
         .left_data  (left_data),
         .right_key  (right_key),
         .right_data (right_data),
         .seen_in    (seen[i]),
         .key        (cell_key[i]),
         .data       (cell_data[i]),
         .seen_out   (seen[i+1])
      );
   end

   // a match anywhere in the occupied part of the row
   assign found = seen[CAPACITY];

   // fill count and response for the accepted operation
   always_comb begin
      fill_in = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_id_in = rsp_id_ff;
      rsp_data_in = rsp_data_ff;
      rsp_status_in = rsp_status_ff;

      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_id_in = '0;
         rsp_data_in = '0;
         rsp_status_in = STATUS_OK;
         case (req_mode)
            MODE_APPEND, MODE_PUSH: begin
               if (ctl.full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  fill_in = fill_ff + FILL_W'(1);
               end
            end
            MODE_POP: begin
               if (ctl.empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  // front record leaves before the row shifts
                  rsp_id_in = cell_key[0];
                  rsp_data_in = cell_data[0];
                  fill_in = fill_ff - FILL_W'(1);
               end
            end
            MODE_DELETE: begin
               if (found) begin
                  fill_in = fill_ff - FILL_W'(1);
               end else begin
                  rsp_status_in = STATUS_NOT_FOUND;
               end
            end
            default: begin
               rsp_status_in = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_id_ff <= rsp_id_in;
      rsp_data_ff <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_id = rsp_id_ff;
   assign rsp_out_data = rsp_data_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   // the count never passes the capacity
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_CODE)
      else $error("fill count above capacity");

   // a pop on an empty store answers empty
   a_pop_empty : assert property (@(posedge clock) disable iff (reset)
      accept && (req_mode == MODE_POP) && (fill_ff == '0)
      |=> rsp_valid && (rsp_status == STATUS_EMPTY) && (fill_ff == '0))
      else $error("pop on empty store mishandled");

   // an accepted insert into a store with room grows the count by one
   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      accept && ((req_mode == MODE_APPEND) || (req_mode == MODE_PUSH))
      && (fill_ff != FULL_CODE)
      |=> (fill_ff == $past(fill_ff) + FILL_W'(1)) && (rsp_status == STATUS_OK))
      else $error("insert did not grow the store");

   // record fields are zero in every response with a failed status
   a_zero_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK)
      |-> (rsp_out_id == '0) && (rsp_out_data == '0))
      else $error("record fields set on a failed operation");
`endif

endmodule

`default_nettype wire
